/* rtl/fenwick_point_set_range_sum_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the Fenwick point-set / range-sum unit
// Clocked property wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef FENWICK_POINT_SET_RANGE_SUM_UNIT_DEFINES_SVH
`define FENWICK_POINT_SET_RANGE_SUM_UNIT_DEFINES_SVH

// Property sampled on clk_i, off while rst_ni is low
`define FPSRS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define FPSRS_ASSERT_IMPL(lbl, ante, cons, msg) \
  `FPSRS_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define FPSRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `FPSRS_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/fpsrs_pkg.sv */
// ---------------------------------------------------------------------------
// fpsrs_pkg
// Types, constants and helpers of the Fenwick point-set / range-sum unit.
// ---------------------------------------------------------------------------
package fpsrs_pkg;

  localparam int MaxEntries = 1024;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int PosW       = AddrW + 1;
  localparam int IdxW       = PosW + 1;
  localparam int DataW      = 64;

  localparam logic [PosW-1:0] EntriesReset = PosW'(MaxEntries);

  // Item commands
  localparam logic CmdSet   = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // Result status codes
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusBad = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [PosW-1:0]         position;
    logic [PosW-1:0]         high_position;
    logic signed [DataW-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] range_sum;
    logic                    status;
  } out_item_t;

  // One memory port pair: write port and read address
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // Lowest set bit of a tree index
  function automatic logic [IdxW-1:0] lowbit(input logic [IdxW-1:0] x);
    lowbit = x & (~x + IdxW'(1));
  endfunction

endpackage

/* rtl/fpsrs_ram.sv */
// ---------------------------------------------------------------------------
// fpsrs_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module fpsrs_ram (
  input  logic                              clk_i,
  input  fpsrs_pkg::ram_req_t               req_i,
  output logic [fpsrs_pkg::DataW-1:0]       rdata_o
);

  logic [fpsrs_pkg::DataW-1:0] mem [fpsrs_pkg::MaxEntries];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read one entry; the read data is registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

/* rtl/fpsrs_ctrl.sv */
// ---------------------------------------------------------------------------
// fpsrs_ctrl
// Sequencer: clearing sweep, validity checks, upward update walk and the
// two downward prefix walks of a range query.
// ---------------------------------------------------------------------------
module fpsrs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  fpsrs_pkg::in_item_t         item_i,
  input  logic                        cfg_we_i,
  input  logic [fpsrs_pkg::PosW-1:0]  cfg_wdata_i,
  output fpsrs_pkg::ram_req_t         tree_req_o,
  output fpsrs_pkg::ram_req_t         plain_req_o,
  input  logic [fpsrs_pkg::DataW-1:0] tree_rdata_i,
  input  logic [fpsrs_pkg::DataW-1:0] plain_rdata_i,
  output logic                        result_valid_o,
  output fpsrs_pkg::out_item_t        result_o
);

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StSetUpd = 3'd2;
  localparam logic [2:0] StUp     = 3'd3;
  localparam logic [2:0] StDown   = 3'd4;

  localparam int AddrW = fpsrs_pkg::AddrW;
  localparam int PosW  = fpsrs_pkg::PosW;
  localparam int IdxW  = fpsrs_pkg::IdxW;
  localparam int DataW = fpsrs_pkg::DataW;

  logic [2:0]              state_q, state_d;
  logic [AddrW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [PosW-1:0]         entries_q;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic [DataW-1:0]        val_q, val_d;
  logic [DataW-1:0]        delta_q, delta_d;
  logic [DataW-1:0]        acc_q, acc_d;
  logic                    phase_q, phase_d;
  logic                    rd_vld_q, rd_vld_d;
  logic                    rd_sub_q, rd_sub_d;
  logic                    wr_pend_q, wr_pend_d;
  logic [AddrW-1:0]        wr_addr_q, wr_addr_d;
  logic                    res_vld_q, res_vld_d;
  fpsrs_pkg::out_item_t    res_q, res_d;

  logic [PosW-1:0]         n_size;
  logic [IdxW-1:0]         idx_m1;
  logic                    set_ok;
  logic                    query_ok;
  logic                    up_live;

  // Effective size: register capped at the memory depth
  assign n_size = (entries_q > fpsrs_pkg::EntriesReset) ? fpsrs_pkg::EntriesReset : entries_q;

  assign set_ok = (item_i.position != '0) && (item_i.position <= n_size);
  assign query_ok = (item_i.position != '0) && (item_i.high_position != '0) &&
                    (item_i.position <= item_i.high_position) &&
                    (item_i.high_position <= n_size);

  assign idx_m1  = idx_q - IdxW'(1);
  assign up_live = (idx_q != '0) && (idx_q <= {1'b0, n_size});

  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // Next-state and memory access logic
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    val_d     = val_q;
    delta_d   = delta_q;
    acc_d     = acc_q;
    phase_d   = phase_q;
    rd_vld_d  = 1'b0;
    rd_sub_d  = rd_sub_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    res_vld_d = 1'b0;
    res_d     = res_q;

    tree_req_o        = '0;
    plain_req_o       = '0;
    tree_req_o.raddr  = idx_m1[AddrW-1:0];
    plain_req_o.raddr = item_i.position[AddrW-1:0] - AddrW'(1);

    // Accumulate a prefix beat that landed this cycle
    if (rd_vld_q) begin
      acc_d = rd_sub_q ? (acc_q - tree_rdata_i) : (acc_q + tree_rdata_i);
    end

    // Retire a pending tree update
    if (wr_pend_q) begin
      tree_req_o.we    = 1'b1;
      tree_req_o.waddr = wr_addr_q;
      tree_req_o.wdata = tree_rdata_i + delta_q;
    end

    case (state_q)
      StClear: begin
        tree_req_o.we     = 1'b1;
        tree_req_o.waddr  = clr_cnt_q;
        tree_req_o.wdata  = '0;
        plain_req_o.we    = 1'b1;
        plain_req_o.waddr = clr_cnt_q;
        plain_req_o.wdata = '0;
        clr_cnt_d         = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start) begin
          if (item_i.cmd == fpsrs_pkg::CmdSet) begin
            if (set_ok) begin
              pos_d   = item_i.position;
              val_d   = item_i.new_value;
              state_d = StSetUpd;
            end else begin
              res_vld_d       = 1'b1;
              res_d.range_sum = '0;
              res_d.status    = fpsrs_pkg::StatusBad;
            end
          end else begin
            if (query_ok) begin
              idx_d   = {1'b0, item_i.high_position};
              pos_d   = item_i.position - PosW'(1);
              acc_d   = '0;
              phase_d = 1'b0;
              state_d = StDown;
            end else begin
              res_vld_d       = 1'b1;
              res_d.range_sum = '0;
              res_d.status    = fpsrs_pkg::StatusBad;
            end
          end
        end
      end
      StSetUpd: begin
        // Old value is on the read port: form the difference, store new value
        delta_d           = val_q - plain_rdata_i;
        plain_req_o.we    = 1'b1;
        plain_req_o.waddr = pos_q[AddrW-1:0] - AddrW'(1);
        plain_req_o.wdata = val_q;
        idx_d             = {1'b0, pos_q};
        state_d           = StUp;
      end
      StUp: begin
        // Read the next node while the previous one is written back
        if (up_live) begin
          wr_pend_d = 1'b1;
          wr_addr_d = idx_m1[AddrW-1:0];
          idx_d     = idx_q + fpsrs_pkg::lowbit(idx_q);
        end else if (!wr_pend_q) begin
          state_d = StIdle;
        end
      end
      StDown: begin
        if (idx_q != '0) begin
          rd_vld_d = 1'b1;
          rd_sub_d = phase_q;
          idx_d    = idx_q - fpsrs_pkg::lowbit(idx_q);
        end else if (!phase_q) begin
          // Switch to the low prefix, subtracted
          idx_d   = {1'b0, pos_q};
          phase_d = 1'b1;
        end else if (!rd_vld_q) begin
          res_vld_d       = 1'b1;
          res_d.range_sum = acc_q;
          res_d.status    = fpsrs_pkg::StatusOk;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
      entries_q <= fpsrs_pkg::EntriesReset;
      rd_vld_q  <= 1'b0;
      rd_sub_q  <= 1'b0;
      wr_pend_q <= 1'b0;
      res_vld_q <= 1'b0;
      phase_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      rd_vld_q  <= rd_vld_d;
      rd_sub_q  <= rd_sub_d;
      wr_pend_q <= wr_pend_d;
      res_vld_q <= res_vld_d;
      phase_q   <= phase_d;
      if (cfg_we_i) begin
        entries_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    delta_q   <= delta_d;
    acc_q     <= acc_d;
    wr_addr_q <= wr_addr_d;
    res_q     <= res_d;
  end

endmodule

/* rtl/fenwick_point_set_range_sum_unit.sv */
// ---------------------------------------------------------------------------
// fenwick_point_set_range_sum_unit
// Binary indexed tree of signed 64-bit values with point set and range sum.
// ---------------------------------------------------------------------------
// After reset the unit holds busy high while it sweeps both memories to
// zero, one entry per cycle; cfg_we_i is taken during that time.
// One item is worked at a time. A set walks up the tree node by node (at
// most 11 nodes on its upward path); a query walks down twice, from high
// and from low-1, visiting one node per set bit of each. Both downward
// walks are set by the single read port of the tree memory, one node per
// cycle. A bad item is answered with status 1 in the cycle after it is
// taken. result_valid_o is a one-cycle strobe that the receiver cannot
// hold off; a successful set gives no result.
// ---------------------------------------------------------------------------
module fenwick_point_set_range_sum_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  fpsrs_pkg::in_item_t        item_i,
  input  logic                       cfg_we_i,
  input  logic [fpsrs_pkg::PosW-1:0] cfg_wdata_i,
  output logic                       result_valid_o,
  output fpsrs_pkg::out_item_t       result_o
);

  fpsrs_pkg::ram_req_t               tree_req;
  fpsrs_pkg::ram_req_t               plain_req;
  logic [fpsrs_pkg::DataW-1:0]       tree_rdata;
  logic [fpsrs_pkg::DataW-1:0]       plain_rdata;

  // Sequencer
  fpsrs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .tree_req_o     (tree_req),
    .plain_req_o    (plain_req),
    .tree_rdata_i   (tree_rdata),
    .plain_rdata_i  (plain_rdata),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Tree node store
  fpsrs_ram u_tree_ram (
    .clk_i   (clk_i),
    .req_i   (tree_req),
    .rdata_o (tree_rdata)
  );

  // Plain value store
  fpsrs_ram u_plain_ram (
    .clk_i   (clk_i),
    .req_i   (plain_req),
    .rdata_o (plain_rdata)
  );

endmodule

/* rtl/fpsrs_checker.sv */
// ---------------------------------------------------------------------------
// fpsrs_checker
// Port-level checks of the Fenwick unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "fenwick_point_set_range_sum_unit_defines.svh"

module fpsrs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 result_valid_o,
  input fpsrs_pkg::out_item_t result_o
);

  // A taken beat either starts work or is answered at once
  `FPSRS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || result_valid_o, "accepted beat lost")

  // A result beat always leaves the unit ready
  `FPSRS_ASSERT_IMPL(a_result_idle, result_valid_o, !busy, "result while busy")

  // No result out of an idle cycle without a beat
  `FPSRS_ASSERT_NEXT(a_no_spurious, !busy && !start, !result_valid_o, "spurious result beat")

  // Error results carry a zero sum
  `FPSRS_ASSERT_IMPL(a_bad_zero, result_valid_o && (result_o.status == fpsrs_pkg::StatusBad), result_o.range_sum == '0, "error result with nonzero sum")

endmodule

bind fenwick_point_set_range_sum_unit fpsrs_checker u_fpsrs_checker (.*);

/* test/fenwick_point_set_range_sum_unit_test.sv */
// ---------------------------------------------------------------------------
// fenwick_point_set_range_sum_unit_test
// Self-checking bench for the point-set / range-sum unit. A directed table
// covers reset contents, field extremes and every bad-item case. Random
// phases follow, one per size setting. Each returned beat is checked against
// the hand-typed answer of a fixed row or a shadow Fenwick tree in the bench.
// ---------------------------------------------------------------------------
module fenwick_point_set_range_sum_unit_test;

  localparam int DataW      = fpsrs_pkg::DataW;
  localparam int PosW       = fpsrs_pkg::PosW;
  localparam int MaxEntries = fpsrs_pkg::MaxEntries;

  localparam int QuietLimit   = 4000;
  localparam int SettleCycles = 20;
  localparam int NumPhases    = 7;

  localparam logic [DataW-1:0] Max64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] Min64 = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0] Alt64 = 64'h5555_AAAA_5555_AAAA;

  // One row of the directed table; fixed rows carry a hand-typed answer
  typedef struct {
    logic             cmd;
    logic [PosW-1:0]  lo;
    logic [PosW-1:0]  hi;
    logic [DataW-1:0] val;
    bit               fixed;
    logic [DataW-1:0] sum;
    logic             status;
  } row_t;

  row_t dir_rows [23] = '{
    '{fpsrs_pkg::CmdQuery, 11'd1,    11'd1024, '0,    1'b1, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd1024, 11'd1024, '1,    1'b1, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdSet,   11'd0,    11'd2047, 64'd5, 1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdSet,   11'd1025, 11'd0,    '1,    1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdSet,   11'd2047, 11'd1,    64'd7, 1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdQuery, 11'd0,    11'd5,    '0,    1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdQuery, 11'd3,    11'd0,    '0,    1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdQuery, 11'd6,    11'd5,    '0,    1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdQuery, 11'd1,    11'd1025, '0,    1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdQuery, 11'd2047, 11'd2047, '0,    1'b1, '0, fpsrs_pkg::StatusBad},
    '{fpsrs_pkg::CmdSet,   11'd1,    11'd0,    Max64, 1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdSet,   11'd1024, 11'd0,    Min64, 1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdSet,   11'd512,  11'd2047, '1,    1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdSet,   11'd1,    11'd0,    64'd5, 1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdSet,   11'd768,  11'd0,    Alt64, 1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdSet,   11'd1023, 11'd0,    Max64, 1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd1,    11'd1,    '0,    1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd1,    11'd1024, Max64, 1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd1024, 11'd1024, '0,    1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd2,    11'd1023, '0,    1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd513,  11'd1024, '0,    1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd1023, 11'd1024, '0,    1'b0, '0, fpsrs_pkg::StatusOk},
    '{fpsrs_pkg::CmdQuery, 11'd1024, 11'd1,    '1,    1'b1, '0, fpsrs_pkg::StatusBad}
  };

  // Size setting and item count of each random phase; -1 picks a random size
  int phase_entries [NumPhases] = '{13, 0, 2047, 1, 1024, 200, -1};
  int phase_items   [NumPhases] = '{70, 15, 70, 30, 80, 70, 65};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  fpsrs_pkg::in_item_t  item;
  logic                 cfg_we;
  logic [PosW-1:0]      cfg_wdata;
  logic                 result_valid;
  fpsrs_pkg::out_item_t result;

  // Shadow copy of both stores and the size register
  logic [DataW-1:0]     tree_sum  [1:MaxEntries];
  logic [DataW-1:0]     point_val [1:MaxEntries];
  logic [PosW-1:0]      num_entries;
  fpsrs_pkg::out_item_t pending_sums [$];
  int                   mismatches  = 0;
  int                   quiet_cycles = 0;

  fenwick_point_set_range_sum_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int active_entries();
    return (num_entries > MaxEntries) ? MaxEntries : int'(num_entries);
  endfunction

  // Sum of positions 1..idx, walking down by the lowest set bit
  function automatic logic [DataW-1:0] prefix_sum(input int idx);
    logic [DataW-1:0] acc;
    acc = '0;
    while (idx != 0) begin
      acc += tree_sum[idx];
      idx -= idx & -idx;
    end
    return acc;
  endfunction

  // Apply one item to the shadow tree and work out the beat it returns
  task automatic fenwick_apply(input fpsrs_pkg::in_item_t it, output bit gives,
                               output fpsrs_pkg::out_item_t res);
    int               n;
    int               lo;
    int               hi;
    int               idx;
    logic [DataW-1:0] delta;
    n = active_entries();
    lo = int'(it.position);
    hi = int'(it.high_position);
    gives = 1'b1;
    res.range_sum = '0;
    res.status = fpsrs_pkg::StatusBad;
    if (it.cmd == fpsrs_pkg::CmdSet) begin
      if (lo != 0 && lo <= n) begin
        gives = 1'b0;
        delta = it.new_value - point_val[lo];
        idx = lo;
        while (idx != 0 && idx <= n) begin
          tree_sum[idx] += delta;
          idx += idx & -idx;
        end
        point_val[lo] = it.new_value;
      end
    end else if (lo != 0 && hi != 0 && lo <= hi && hi <= n) begin
      res.range_sum = prefix_sum(hi) - prefix_sum(lo - 1);
      res.status = fpsrs_pkg::StatusOk;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Check each result beat against the oldest pending answer
  always @(posedge clk_i) begin : result_check
    fpsrs_pkg::out_item_t want;
    if (rst_ni === 1'b1 && result_valid === 1'b1) begin
      if (pending_sums.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: sum %0d status %0b",
                                result.range_sum, result.status));
      end else begin
        want = pending_sums.pop_front();
        if (result.range_sum !== want.range_sum)
          flag_mismatch($sformatf("range_sum %0d, want %0d", result.range_sum,
                                  want.range_sum));
        if (result.status !== want.status)
          flag_mismatch($sformatf("status %0b, want %0b", result.status, want.status));
      end
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || result_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("fenwick_point_set_range_sum_unit_test failed");
      $finish;
    end
  end

  // Present one item, hold it until taken, then idle for gap cycles
  task automatic send_item(input fpsrs_pkg::in_item_t it, input int gap, input bit fixed,
                           input fpsrs_pkg::out_item_t fixed_res);
    bit                   gives;
    fpsrs_pkg::out_item_t res;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    fenwick_apply(it, gives, res);
    if (fixed) begin
      pending_sums.push_back(fixed_res);
    end else if (gives) begin
      pending_sums.push_back(res);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drop start and hold off until every pending beat has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the size register once the unit has gone quiet
  task automatic write_entries(input logic [PosW-1:0] value);
    while (busy !== 1'b0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    num_entries = value;
  endtask

  function automatic logic [DataW-1:0] rand_value();
    longint near_zero;
    near_zero = longint'($urandom_range(0, 200)) - 100;
    case ($urandom_range(0, 9))
      0:       return Max64;
      1:       return Min64;
      2:       return '1;
      3, 4:    return near_zero;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [PosW-1:0] rand_pos(input int n);
    case ($urandom_range(0, 9))
      0:       return PosW'(1);
      1:       return PosW'(n);
      default: return PosW'($urandom_range(1, n));
    endcase
  endfunction

  // Mostly well-formed items inside the active size, some raw noise
  function automatic fpsrs_pkg::in_item_t rand_item(input int n);
    fpsrs_pkg::in_item_t it;
    logic [PosW-1:0]     a;
    logic [PosW-1:0]     b;
    it.cmd = $urandom_range(0, 1) ? fpsrs_pkg::CmdQuery : fpsrs_pkg::CmdSet;
    it.position = PosW'($urandom);
    it.high_position = PosW'($urandom);
    it.new_value = {$urandom, $urandom};
    if (n > 0 && $urandom_range(0, 99) >= 12) begin
      it.new_value = rand_value();
      a = rand_pos(n);
      b = rand_pos(n);
      if (it.cmd == fpsrs_pkg::CmdSet) begin
        it.position = a;
      end else begin
        it.position = (a < b) ? a : b;
        it.high_position = (a < b) ? b : a;
      end
    end
    return it;
  endfunction

  // Mostly short gaps, a few long ones, none inside a burst
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  initial begin
    fpsrs_pkg::out_item_t typed_res;
    fpsrs_pkg::in_item_t  it;
    row_t                 row;
    int                   n;
    bit                   burst;
    logic [PosW-1:0]      setting;
    rst_ni    = 1'b0;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int i = 1; i <= MaxEntries; i++) begin
      tree_sum[i]  = '0;
      point_val[i] = '0;
    end
    num_entries = fpsrs_pkg::EntriesReset;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table at the reset size
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      it.cmd = row.cmd;
      it.position = row.lo;
      it.high_position = row.hi;
      it.new_value = row.val;
      typed_res.range_sum = row.sum;
      typed_res.status = row.status;
      send_item(it, pick_gap(1'b0), row.fixed, typed_res);
    end

    // Random phases, one per size setting
    typed_res = '0;
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      if (phase_entries[p] < 0) begin
        setting = PosW'($urandom_range(2, MaxEntries));
      end else begin
        setting = PosW'(phase_entries[p]);
      end
      write_entries(setting);
      n = active_entries();
      burst = 1'b0;
      for (int k = 0; k < phase_items[p]; k++) begin
        if (k % 16 == 0) burst = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) < 3) wait_drained();
        send_item(rand_item(n), pick_gap(burst), 1'b0, typed_res);
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_sums.size() == 0) begin
      $display("fenwick_point_set_range_sum_unit_test passed");
    end else begin
      $display("fenwick_point_set_range_sum_unit_test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fpsrs_pkg.sv
rtl/fpsrs_ram.sv
rtl/fpsrs_ctrl.sv
rtl/fenwick_point_set_range_sum_unit.sv
rtl/fpsrs_checker.sv
test/fenwick_point_set_range_sum_unit_test.sv
